FILE: design/ped_pkg.sv
package ped_pkg;

    localparam int QUEUE_DEPTH = 4;
    localparam int MAX_BYTES   = 6;

    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_LC_U   = 8'h75;
    localparam logic [7:0] CH_LC_N   = 8'h6E;
    localparam logic [7:0] CH_LC_T   = 8'h74;
    localparam logic [7:0] CH_LC_R   = 8'h72;
    localparam logic [7:0] CH_LC_F   = 8'h66;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_FF     = 8'h0C;

    localparam logic [7:0]  UTF8_LEAD2 = 8'hC0;
    localparam logic [7:0]  UTF8_LEAD3 = 8'hE0;
    localparam logic [7:0]  UTF8_CONT  = 8'h80;
    localparam logic [7:0]  UTF8_MASK  = 8'h3F;
    localparam logic [15:0] UTF8_TWO   = 16'h0080;
    localparam logic [15:0] UTF8_THREE = 16'h0800;

    // one decoded input: up to six output words and the end-of-string flag
    typedef struct packed {
        logic [MAX_BYTES-1:0][7:0] bytes;
        logic [2:0]                cnt;
        logic                      last;
    } t_cmd;

endpackage

FILE: design/ped_in_if.sv
interface ped_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       in_last;

    modport source (output valid, output in_byte, output in_last, input ready);
    modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

FILE: design/ped_out_if.sv
interface ped_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       run_last;
    logic       string_end;

    modport source (output valid, output out_byte, output run_last, output string_end,
                    input ready);
    modport sink   (input valid, input out_byte, input run_last, input string_end,
                    output ready);
endinterface

FILE: design/ped_front.sv
module ped_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    ped_in_if.sink        i_in,
    input  logic          i_full,
    output logic          o_push,
    output ped_pkg::t_cmd o_cmd
);
    import ped_pkg::*;

    localparam logic [1:0] MODE_PLAIN = 2'd0;
    localparam logic [1:0] MODE_ESC   = 2'd1;
    localparam logic [1:0] MODE_HEX   = 2'd2;

    logic [1:0]       r_mode, n_mode;
    logic [1:0]       r_dc, n_dc;
    logic [11:0]      r_code, n_code;
    logic [2:0][7:0]  r_held;

    logic             accept;
    logic [7:0]       b;
    logic             lst;
    logic             is_hex;
    logic [3:0]       hv;
    logic [15:0]      cp;
    logic             is_bs;
    logic             held_wr;
    logic [MAX_BYTES-1:0][7:0] flush_bytes;

    always_comb begin
        b      = i_in.in_byte;
        lst    = i_in.in_last;
        is_bs  = (b == CH_BSLASH);
        is_hex = 1'b1;
        hv     = 4'd0;
        if (b >= 8'h30 && b <= 8'h39) begin
            hv = 4'(b - 8'h30);
        end else if (b >= 8'h61 && b <= 8'h66) begin
            hv = 4'(b - 8'h57);
        end else if (b >= 8'h41 && b <= 8'h46) begin
            hv = 4'(b - 8'h37);
        end else begin
            is_hex = 1'b0;
        end
        cp = {r_code, hv};
    end

    // literal pass-through of a broken escape: backslash, u, held digits, then the byte
    always_comb begin
        flush_bytes[0] = CH_BSLASH;
        flush_bytes[1] = CH_LC_U;
        for (int i = 0; i < 3; i++) begin
            if (i < int'(r_dc)) begin
                flush_bytes[i + 2] = r_held[2'(i)];
            end else begin
                flush_bytes[i + 2] = b;
            end
        end
        flush_bytes[MAX_BYTES-1] = b;
    end

    assign i_in.ready = !i_full;
    assign accept     = i_in.valid && !i_full;

    always_comb begin
        n_mode     = MODE_PLAIN;
        n_dc       = r_dc;
        n_code     = r_code;
        held_wr    = 1'b0;
        o_cmd      = '0;
        o_cmd.last = lst;
        case (r_mode)
            MODE_ESC: begin
                if (b == CH_LC_N) begin
                    o_cmd.bytes[0] = CH_LF;
                    o_cmd.cnt      = 3'd1;
                end else if (b == CH_LC_T) begin
                    o_cmd.bytes[0] = CH_TAB;
                    o_cmd.cnt      = 3'd1;
                end else if (b == CH_LC_R) begin
                    o_cmd.bytes[0] = CH_CR;
                    o_cmd.cnt      = 3'd1;
                end else if (b == CH_LC_F) begin
                    o_cmd.bytes[0] = CH_FF;
                    o_cmd.cnt      = 3'd1;
                end else if (b == CH_LC_U) begin
                    n_dc   = 2'd0;
                    n_code = '0;
                    if (lst) begin
                        o_cmd.bytes[0] = CH_BSLASH;
                        o_cmd.bytes[1] = CH_LC_U;
                        o_cmd.cnt      = 3'd2;
                    end else begin
                        n_mode = MODE_HEX;
                    end
                end else begin
                    o_cmd.bytes[0] = b;
                    o_cmd.cnt      = 3'd1;
                end
            end
            MODE_HEX: begin
                if (is_hex) begin
                    if (r_dc == 2'd3) begin
                        n_dc   = 2'd0;
                        n_code = '0;
                        if (cp < UTF8_TWO) begin
                            o_cmd.bytes[0] = cp[7:0];
                            o_cmd.cnt      = 3'd1;
                        end else if (cp < UTF8_THREE) begin
                            o_cmd.bytes[0] = UTF8_LEAD2 | {3'd0, cp[10:6]};
                            o_cmd.bytes[1] = UTF8_CONT | (cp[7:0] & UTF8_MASK);
                            o_cmd.cnt      = 3'd2;
                        end else begin
                            o_cmd.bytes[0] = UTF8_LEAD3 | {4'd0, cp[15:12]};
                            o_cmd.bytes[1] = UTF8_CONT | {2'd0, cp[11:6]};
                            o_cmd.bytes[2] = UTF8_CONT | (cp[7:0] & UTF8_MASK);
                            o_cmd.cnt      = 3'd3;
                        end
                    end else if (lst) begin
                        o_cmd.bytes = flush_bytes;
                        o_cmd.cnt   = 3'd3 + {1'b0, r_dc};
                    end else begin
                        n_mode  = MODE_HEX;
                        n_dc    = r_dc + 2'd1;
                        n_code  = cp[11:0];
                        held_wr = 1'b1;
                    end
                end else begin
                    n_dc        = 2'd0;
                    n_code      = '0;
                    o_cmd.bytes = flush_bytes;
                    if (is_bs && !lst) begin
                        n_mode    = MODE_ESC;
                        o_cmd.cnt = 3'd2 + {1'b0, r_dc};
                    end else begin
                        o_cmd.cnt = 3'd3 + {1'b0, r_dc};
                    end
                end
            end
            default: begin
                if (is_bs && !lst) begin
                    n_mode = MODE_ESC;
                end else begin
                    o_cmd.bytes[0] = b;
                    o_cmd.cnt      = 3'd1;
                end
            end
        endcase
        if (lst) begin
            n_mode = MODE_PLAIN;
            n_dc   = 2'd0;
            n_code = '0;
        end
    end

    assign o_push = accept && (o_cmd.cnt != 3'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_PLAIN;
            r_dc   <= 2'd0;
            r_code <= '0;
        end else if (accept) begin
            r_mode <= n_mode;
            r_dc   <= n_dc;
            r_code <= n_code;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && held_wr) begin
            r_held[r_dc] <= b;
        end
    end

endmodule

FILE: design/ped_queue.sv
module ped_queue #(
    parameter int P_DEPTH = ped_pkg::QUEUE_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  ped_pkg::t_cmd i_cmd,
    input  logic          i_pop,
    output logic          o_full,
    output logic          o_valid,
    output ped_pkg::t_cmd o_head
);
    import ped_pkg::*;

    localparam int PW = (P_DEPTH > 1) ? $clog2(P_DEPTH) : 1;
    localparam int CW = $clog2(P_DEPTH + 1);

    t_cmd            r_mem [P_DEPTH];
    logic [PW-1:0]   r_wr, r_rd;
    logic [CW-1:0]   r_count;
    logic            do_push, do_pop;

    assign o_full  = (r_count == CW'(P_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PW'(P_DEPTH - 1)) ? '0 : r_wr + PW'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == PW'(P_DEPTH - 1)) ? '0 : r_rd + PW'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CW'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

endmodule

FILE: design/ped_back.sv
module ped_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_head_valid,
    input  ped_pkg::t_cmd i_head,
    output logic          o_pop,
    output logic [2:0]    o_idx,
    ped_out_if.source     o_out
);
    import ped_pkg::*;

    logic       r_valid;
    logic [7:0] r_byte;
    logic       r_run_last;
    logic       r_end;
    logic [2:0] r_idx;
    logic       load;
    logic       fin;

    assign load  = i_head_valid && (!r_valid || o_out.ready);
    assign fin   = (r_idx == i_head.cnt - 3'd1);
    assign o_pop = load && fin;
    assign o_idx = r_idx;

    assign o_out.valid      = r_valid;
    assign o_out.out_byte   = r_byte;
    assign o_out.run_last   = r_run_last;
    assign o_out.string_end = r_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 3'd0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_idx   <= fin ? 3'd0 : r_idx + 3'd1;
            end else if (o_out.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_byte     <= i_head.bytes[r_idx];
            r_run_last <= fin;
            r_end      <= fin && i_head.last;
        end
    end

endmodule

FILE: design/properties_escape_decoder_core.sv
// path: an accepted input word goes into the command queue, then into the output register
// throughput: one input word per cycle unless the queue is full; an input that yields n
//   output words (up to six) sends each in turn; a four-entry queue absorbs short bursts
// reset: synchronous active-low i_rst_n returns the decoder to plain text and empties
//   the queue and output register
module properties_escape_decoder_core #(
    parameter int P_QUEUE_DEPTH = ped_pkg::QUEUE_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ped_in_if.sink     i_in,
    ped_out_if.source  o_out
);
    import ped_pkg::*;

    logic  push, full, head_valid, pop;
    t_cmd  cmd, head;
    logic [2:0] idx;

    ped_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_full  (full),
        .o_push  (push),
        .o_cmd   (cmd)
    );

    ped_queue #(
        .P_DEPTH (P_QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (cmd),
        .i_pop   (pop),
        .o_full  (full),
        .o_valid (head_valid),
        .o_head  (head)
    );

    ped_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (head_valid),
        .i_head       (head),
        .o_pop        (pop),
        .o_idx        (idx),
        .o_out        (o_out)
    );

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(push && full))
        else $error("command pushed into a full queue");

    a_cmd_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> (cmd.cnt != 3'd0 && cmd.cnt <= 3'd6))
        else $error("queued command has a bad word count");

    a_idx_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        head_valid |-> (idx < head.cnt))
        else $error("back-end index beyond command length");

    a_end_on_run_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.string_end) |-> o_out.run_last)
        else $error("string end flagged on a word that is not the last of its run");

endmodule
